### rtl/imu_fp_pkg.sv
// Shared constants and types for the IMU frame parser.
// No dependencies; imported by imu_fp_core and imu_frame_parser_top.
package imu_fp_pkg;

	localparam int BYTE_W      = 8;
	localparam int VALUE_BYTES = 4;
	localparam int VALUE_W     = VALUE_BYTES * BYTE_W;
	localparam int AXES        = 3;
	localparam int NUM_VALUES  = 2 * AXES;
	localparam int RECORD_BYTES = AXES * VALUE_BYTES;

	localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h59;
	localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h53;

	localparam logic [BYTE_W-1:0] ACCEL_REC_ID_RST = 8'd16;
	localparam logic [BYTE_W-1:0] EULER_REC_ID_RST = 8'd64;
	localparam logic [BYTE_W-1:0] ACCEL_LEN_RST    = 8'd12;
	localparam logic [BYTE_W-1:0] EULER_LEN_RST    = 8'd12;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_REC_ID = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EULER_REC_ID = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LEN    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EULER_LEN    = 2'd3;

	// result word layout: two update flags, then six values
	localparam int OUT_BITS = 2 + NUM_VALUES * VALUE_W;
	localparam int TDATA_W  = ((OUT_BITS + 7) / 8) * 8;
	localparam int PAD_W    = TDATA_W - OUT_BITS;

	typedef struct packed {
		logic [BYTE_W-1:0] accel_rec_id;
		logic [BYTE_W-1:0] euler_rec_id;
		logic [BYTE_W-1:0] accel_len;
		logic [BYTE_W-1:0] euler_len;
	} imu_fp_cfg_t;

	typedef struct packed {
		logic                                  frame_status;
		logic                                  accel_updated;
		logic                                  euler_updated;
		logic [NUM_VALUES-1:0][VALUE_W-1:0]    values;
	} imu_fp_result_t;

endpackage

### rtl/imu_fp_core.sv
// Frame state machine, Fletcher-style mod-256 sums, record walker and value registers.
// Depends on imu_fp_pkg.
module imu_fp_core
	import imu_fp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [BYTE_W-1:0] rx_byte,
	input  imu_fp_cfg_t       cfg,
	output logic              result_due,
	output imu_fp_result_t    result
);

	localparam logic [2:0] PH_HUNT1   = 3'd0;
	localparam logic [2:0] PH_HUNT2   = 3'd1;
	localparam logic [2:0] PH_ID0     = 3'd2;
	localparam logic [2:0] PH_ID1     = 3'd3;
	localparam logic [2:0] PH_LEN     = 3'd4;
	localparam logic [2:0] PH_PAYLOAD = 3'd5;
	localparam logic [2:0] PH_CK1     = 3'd6;
	localparam logic [2:0] PH_CK2     = 3'd7;

	localparam logic [1:0] RP_ID   = 2'd0;
	localparam logic [1:0] RP_LEN  = 2'd1;
	localparam logic [1:0] RP_DATA = 2'd2;

	logic [2:0]        phase_q, phase_d;
	logic [BYTE_W-1:0] sum_low_q, sum_low_d, sum_high_q, sum_high_d;
	logic [BYTE_W-1:0] payload_left_q, payload_left_d;
	logic [1:0]        rec_phase_q, rec_phase_d;
	logic [BYTE_W-1:0] cand_id_q, cand_id_d;
	logic [BYTE_W-1:0] rec_left_q, rec_left_d;
	logic              rec_kind_q, rec_kind_d;
	logic [BYTE_W-1:0] check_low_q, check_low_d;
	logic [1:0]        flags_q, flags_d;

	logic [VALUE_BYTES-1:0][BYTE_W-1:0] shadow_q [NUM_VALUES];
	logic [NUM_VALUES-1:0][VALUE_W-1:0] committed_q, committed_d;

	logic [BYTE_W-1:0] sum_low_add, sum_high_add;
	logic              len_match, len_kind;
	logic [BYTE_W-1:0] cur_len;
	logic [BYTE_W:0]   offset;
	logic              shadow_we;
	logic [2:0]        shadow_idx;
	logic [1:0]        shadow_lane;
	logic              good;

	assign sum_low_add  = sum_low_q + rx_byte;
	assign sum_high_add = sum_high_q + sum_low_add;

	// id/length match for a candidate record; accel id wins on a tie
	always_comb begin
		len_match = 1'b0;
		len_kind  = 1'b0;
		priority if (cand_id_q == cfg.accel_rec_id) begin
			len_match = (rx_byte == cfg.accel_len);
		end else if (cand_id_q == cfg.euler_rec_id) begin
			len_match = (rx_byte == cfg.euler_len);
			len_kind  = 1'b1;
		end
	end

	// byte offset within the record data; a borrow means no value byte
	assign cur_len     = rec_kind_q ? cfg.euler_len : cfg.accel_len;
	assign offset      = {1'b0, cur_len} - {1'b0, rec_left_q};
	assign shadow_lane = offset[1:0];
	assign shadow_idx  = rec_kind_q ? (3'(AXES) + {1'b0, offset[3:2]}) : {1'b0, offset[3:2]};

	assign good       = (check_low_q == sum_low_q) && (rx_byte == sum_high_q);
	assign result_due = (phase_q == PH_CK2);

	always_comb begin
		phase_d        = phase_q;
		sum_low_d      = sum_low_q;
		sum_high_d     = sum_high_q;
		payload_left_d = payload_left_q;
		rec_phase_d    = rec_phase_q;
		cand_id_d      = cand_id_q;
		rec_left_d     = rec_left_q;
		rec_kind_d     = rec_kind_q;
		check_low_d    = check_low_q;
		flags_d        = flags_q;
		committed_d    = committed_q;
		shadow_we      = 1'b0;

		unique case (phase_q)
			PH_HUNT1: begin
				if (rx_byte == HDR_FIRST) phase_d = PH_HUNT2;
			end
			PH_HUNT2: begin
				if (rx_byte == HDR_SECOND) begin
					sum_low_d  = '0;
					sum_high_d = '0;
					phase_d    = PH_ID0;
				end else if (rx_byte != HDR_FIRST) begin
					phase_d = PH_HUNT1;
				end
			end
			PH_ID0: begin
				sum_low_d  = sum_low_add;
				sum_high_d = sum_high_add;
				phase_d    = PH_ID1;
			end
			PH_ID1: begin
				sum_low_d  = sum_low_add;
				sum_high_d = sum_high_add;
				phase_d    = PH_LEN;
			end
			PH_LEN: begin
				sum_low_d      = sum_low_add;
				sum_high_d     = sum_high_add;
				payload_left_d = rx_byte;
				rec_phase_d    = RP_ID;
				rec_left_d     = '0;
				flags_d        = '0;
				phase_d        = (rx_byte == '0) ? PH_CK1 : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				sum_low_d      = sum_low_add;
				sum_high_d     = sum_high_add;
				payload_left_d = payload_left_q - 8'd1;
				if (payload_left_q == 8'd1) phase_d = PH_CK1;
				unique case (rec_phase_q)
					RP_ID: begin
						cand_id_d   = rx_byte;
						rec_phase_d = RP_LEN;
					end
					RP_LEN: begin
						// accept only if the data ends inside the payload
						if (len_match && rx_byte >= 8'(RECORD_BYTES)
								&& rx_byte < payload_left_q) begin
							rec_kind_d  = len_kind;
							rec_left_d  = rx_byte;
							rec_phase_d = RP_DATA;
						end else begin
							cand_id_d   = rx_byte;
							rec_phase_d = RP_LEN;
						end
					end
					RP_DATA: begin
						shadow_we  = !offset[BYTE_W] && (offset[BYTE_W-1:0] < 8'(RECORD_BYTES));
						rec_left_d = rec_left_q - 8'd1;
						if (rec_left_q == 8'd1) begin
							flags_d     = flags_q | (rec_kind_q ? 2'b10 : 2'b01);
							rec_phase_d = RP_ID;
						end
					end
					default: begin
						rec_phase_d = RP_ID;
					end
				endcase
			end
			PH_CK1: begin
				check_low_d = rx_byte;
				phase_d     = PH_CK2;
			end
			PH_CK2: begin
				phase_d = PH_HUNT1;
				flags_d = '0;
				if (good) begin
					for (int i = 0; i < AXES; i++) begin
						if (flags_q[0]) committed_d[i] = shadow_q[i];
						if (flags_q[1]) committed_d[AXES+i] = shadow_q[AXES+i];
					end
				end
			end
			default: begin
				phase_d = PH_HUNT1;
			end
		endcase
	end

	always_comb begin
		result.frame_status  = !good;
		result.accel_updated = good && flags_q[0];
		result.euler_updated = good && flags_q[1];
		result.values        = committed_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HUNT1;
			sum_low_q      <= '0;
			sum_high_q     <= '0;
			payload_left_q <= '0;
			rec_phase_q    <= RP_ID;
			cand_id_q      <= '0;
			rec_left_q     <= '0;
			rec_kind_q     <= 1'b0;
			check_low_q    <= '0;
			flags_q        <= '0;
			committed_q    <= '0;
		end else if (step) begin
			phase_q        <= phase_d;
			sum_low_q      <= sum_low_d;
			sum_high_q     <= sum_high_d;
			payload_left_q <= payload_left_d;
			rec_phase_q    <= rec_phase_d;
			cand_id_q      <= cand_id_d;
			rec_left_q     <= rec_left_d;
			rec_kind_q     <= rec_kind_d;
			check_low_q    <= check_low_d;
			flags_q        <= flags_d;
			committed_q    <= committed_d;
		end
	end

	// value bytes land little-endian in their lane
	always_ff @(posedge clk) begin
		if (step && shadow_we) begin
			shadow_q[shadow_idx][shadow_lane] <= rx_byte;
		end
	end

	a_ck2_returns_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_CK2 |=> phase_q == PH_HUNT1 && flags_q == 2'b00)
		else $error("frame end did not return to header hunt");

	a_record_inside_payload: assert property (@(posedge clk) disable iff (!arst_n)
		rec_phase_q == RP_DATA |-> phase_q == PH_PAYLOAD && rec_left_q != 8'd0)
		else $error("record data outlived the payload");

	a_bad_frame_no_update: assert property (@(posedge clk) disable iff (!arst_n)
		step && result_due && result.frame_status |=> $stable(committed_q))
		else $error("bad checksum changed committed values");

	a_empty_len_skips_payload: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_LEN && rx_byte == 8'd0 |=> phase_q == PH_CK1)
		else $error("empty payload did not go to check bytes");

endmodule

### rtl/imu_frame_parser_top.sv
// Top level of the IMU frame parser: stream handshakes, input and result registers.
// Depends on imu_fp_pkg and imu_fp_core.
//
// Usage:
//   s_axis carries one received serial byte per word in s_axis_tdata[7:0].
//   The block hunts for the header 0x59 0x53, then reads id, length, payload
//   and two Fletcher-style (mod 256) check bytes. After the second check byte one result
//   word leaves on m_axis: m_axis_tuser is the frame status (0 accepted,
//   1 checksum mismatch) and m_axis_tdata holds the update flags and the six
//   committed raw values.
//   Throughput: one byte per cycle unless a stall holds the input register.
//   Each byte sits in the input register while the frame state machine
//   updates; the result register loads as the second check byte leaves the
//   input register and drives m_axis_tvalid.
//   Stall: the result register holds until taken. Bytes keep flowing while a
//   result waits; only a second result stuck behind a full, stalled result
//   register holds the input register and drops s_axis_tready.
//   Reset: arst_n clears the frame state, committed values (to zero) and the
//   configuration (ids 16 and 64, lengths 12). Write cfg_* between words only.
module imu_frame_parser_top
	import imu_fp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	// byte stream in
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [BYTE_W-1:0]    s_axis_tdata,   // [7:0] rx_byte
	// result stream out
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// [0] accel_updated, [1] euler_updated, [33:2] accel_x_raw, [65:34] accel_y_raw,
	// [97:66] accel_z_raw, [129:98] pitch_raw, [161:130] roll_raw,
	// [193:162] yaw_raw, [199:194] zero
	output logic [TDATA_W-1:0]   m_axis_tdata,
	output logic                 m_axis_tuser    // [0] frame_status
);

	imu_fp_cfg_t       cfg_q;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              result_due;
	imu_fp_result_t    result;
	imu_fp_result_t    out_q;
	logic              out_valid_q;
	logic              advance;
	logic              step;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accel_rec_id <= ACCEL_REC_ID_RST;
			cfg_q.euler_rec_id <= EULER_REC_ID_RST;
			cfg_q.accel_len    <= ACCEL_LEN_RST;
			cfg_q.euler_len    <= EULER_LEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ACCEL_REC_ID: cfg_q.accel_rec_id <= cfg_data;
				REG_EULER_REC_ID: cfg_q.euler_rec_id <= cfg_data;
				REG_ACCEL_LEN:    cfg_q.accel_len    <= cfg_data;
				REG_EULER_LEN:    cfg_q.euler_len    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Hold the byte in the input register only when it would produce a result
	// and the result register is full and not being drained.
	assign advance       = !(result_due && out_valid_q && !m_axis_tready);
	assign step          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	imu_fp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.rx_byte    (byte_s1),
		.cfg        (cfg_q),
		.result_due (result_due),
		.result     (result)
	);

	// result register: load on frame end, clear when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && result_due) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && result_due) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.frame_status;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, out_q.values, out_q.euler_updated,
		out_q.accel_updated};

endmodule
